>>> sv/ahvs_pkg.sv
// Shared types, codes and constants for the additive harmonic voice synthesizer.
// Used by ahvs_mul and additive_harmonic_voice_synth_unit; depends on nothing.
package ahvs_pkg;

  localparam int HARMONIC_COUNT_DEF  = 7;
  localparam int SINE_TABLE_BITS_DEF = 10;
  localparam int PACKED_GAINS        = 7;

  // Operand width of the shared multiplier.
  localparam int OPW = 33;

  typedef logic signed [OPW-1:0]   op_t;
  typedef logic signed [2*OPW-1:0] prod_t;

  // Rounding shift applied to a product (round half away from zero).
  typedef enum logic [2:0] {
    SH_0,
    SH_16,
    SH_22,
    SH_28,
    SH_30
  } shift_t;

  typedef struct packed {
    op_t    a;
    op_t    b;
    shift_t sh;
  } mul_req_t;

  // Configuration register indexes.
  localparam logic [2:0] REG_GLIDE   = 3'd0;
  localparam logic [2:0] REG_ATTACK  = 3'd1;
  localparam logic [2:0] REG_RELEASE = 3'd2;
  localparam logic [2:0] REG_PERC    = 3'd3;
  localparam logic [2:0] REG_MASTER  = 3'd4;
  localparam logic [2:0] REG_VIBSTEP = 3'd5;
  localparam logic [2:0] REG_GAINS   = 3'd6;

  // Smoothing constants of the master gain and vibrato depth followers.
  localparam logic [15:0] MASTER_K = 16'd655;
  localparam logic [15:0] DEPTH_K  = 16'd7;

  // Quarter turn of a 24-bit phase, used to turn sine into cosine.
  localparam logic [23:0] QUARTER_TURN = 24'h400000;

  // Q30 coefficients of the odd sine polynomial, highest order first.
  function automatic op_t sin_coef(input logic [2:0] k);
    op_t c;
    case (k)
      3'd0:    c = 33'sd172273;
      3'd1:    c = -33'sd5026995;
      3'd2:    c = 33'sd85569306;
      3'd3:    c = -33'sd693598668;
      3'd4:    c = 33'sd1686629713;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

>>> sv/additive_harmonic_voice_synth_unit.sv
// Top level of the additive harmonic voice synthesizer.
// Depends on ahvs_pkg and instantiates the shared multiplier ahvs_mul.
//
// Usage: one input beat per audio sample carries the target phase step, the
// target level, the vibrato depth target and an external sample; one output
// beat carries the saturated audio sample. Both channels use valid/stall.
// Registers are written over the APB-style port at byte address 8*i.
//
// Sequencing: every product goes through one shared multiplier under a
// sequencer. An item passes through the follower updates, then the vibrato
// cosine, the vibrato offset, one sine evaluation plus one accumulate for
// each of the HARMONIC_COUNT harmonics, and the scaling. The block takes no
// new item until it is back in idle, which it reaches once the result is in
// the output register.
//
// Reset puts state and registers at their documented values and the block
// ready. A stalled result holds in the output register; the block takes the
// next item meanwhile but holds its finished result until the register frees.
module additive_harmonic_voice_synth_unit
  import ahvs_pkg::*;
#(
  parameter int HARMONIC_COUNT  = HARMONIC_COUNT_DEF,
  parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [22:0]        target_step,
  input  logic [15:0]        target_level,
  input  logic [15:0]        vibrato_depth_target,
  input  logic signed [15:0] external_sample,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] audio_sample,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);

  localparam int QB = SINE_TABLE_BITS - 2;
  localparam int HW = (HARMONIC_COUNT > 1) ? $clog2(HARMONIC_COUNT) : 1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MASTER,
    S_GLIDE,
    S_ENV_UP,
    S_ENV_DN,
    S_DEPTH,
    S_OFS_A,
    S_OFS_B,
    S_HARM,
    S_SCALE,
    S_OUT,
    S_SIN_LD,
    S_SIN_T2,
    S_SIN_POLY,
    S_SIN_PT,
    S_SIN_FIN
  } state_t;

  // Configuration registers.
  logic [15:0] glide_coef;
  logic [15:0] attack_coef;
  logic [15:0] release_coef;
  logic        percussive_mode;
  logic [15:0] master_level;
  logic [23:0] vibrato_step;
  logic [55:0] harmonic_gains;

  // Voice state.
  logic [23:0] osc_phase;
  logic [23:0] vib_phase;
  logic [23:0] glided_step;
  logic [15:0] env_level;
  logic [15:0] vib_depth;
  logic [15:0] master_smoothed;

  // Latched input item.
  logic [22:0]        tstep;
  logic [15:0]        tlevel;
  logic [15:0]        tdepth;
  logic signed [15:0] ext;

  // Sequencer working registers.
  state_t          state;
  state_t          ret;
  logic [23:0]     sin_ph;
  logic [1:0]      quad;
  logic [30:0]     t;
  logic [30:0]     t2;
  op_t             acc;
  logic [2:0]      k;
  logic signed [16:0] sinv;
  op_t             prod1;
  logic [23:0]     arg;
  logic [HW-1:0]   hidx;
  op_t             sum;
  op_t             s;

  mul_req_t mreq;
  prod_t    mres;

  // Sine point decode from the sequencer phase.
  logic [SINE_TABLE_BITS-1:0] sidx;
  logic [QB:0]                frac;
  logic [7:0]                 gain;
  logic signed [19:0]         sin_rnd;
  logic signed [16:0]         sin_mag;
  logic signed [65:0]         out_r;
  logic                       wr_en;

  ahvs_mul u_mul (
    .req (mreq),
    .res (mres)
  );

  assign pready   = 1'b1;
  assign in_stall = (state != S_IDLE);
  assign wr_en    = psel && penable && pwrite && pready;

  // Register read-back.
  always_comb begin
    case (paddr[5:3])
      REG_GLIDE:   prdata = 64'(glide_coef);
      REG_ATTACK:  prdata = 64'(attack_coef);
      REG_RELEASE: prdata = 64'(release_coef);
      REG_PERC:    prdata = 64'(percussive_mode);
      REG_MASTER:  prdata = 64'(master_level);
      REG_VIBSTEP: prdata = 64'(vibrato_step);
      REG_GAINS:   prdata = 64'(harmonic_gains);
      default:     prdata = '0;
    endcase
  end

  // Folded sine point and the gain of the current harmonic.
  always_comb begin
    sidx = sin_ph[23 -: SINE_TABLE_BITS];
    frac = sidx[SINE_TABLE_BITS-2] ? ((QB+1)'(1) << QB) - (QB+1)'(sidx[QB-1:0])
                                   : (QB+1)'(sidx[QB-1:0]);
    gain = '0;
    for (int g = 0; g < PACKED_GAINS; g++) begin
      if (int'(hidx) == g) begin
        gain = harmonic_gains[8*g +: 8];
      end
    end
    sin_rnd = 20'(($signed(acc) + 33'sd16384) >>> 15);
    if (acc < 0) begin
      sin_mag = '0;
    end else if (sin_rnd > 20'sd32767) begin
      sin_mag = 17'sd32767;
    end else begin
      sin_mag = 17'(sin_rnd);
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mreq.a  = '0;
    mreq.b  = '0;
    mreq.sh = SH_0;
    case (state)
      S_MASTER: begin
        mreq.a  = $signed({17'd0, master_level}) - $signed({17'd0, master_smoothed});
        mreq.b  = op_t'(MASTER_K);
        mreq.sh = SH_16;
      end
      S_GLIDE: begin
        mreq.a  = $signed({10'd0, tstep}) - $signed({9'd0, glided_step});
        mreq.b  = op_t'(17'h10000 - {1'b0, glide_coef});
        mreq.sh = SH_16;
      end
      S_ENV_UP: begin
        mreq.a  = $signed({17'd0, tlevel}) - $signed({17'd0, env_level});
        mreq.b  = op_t'(attack_coef);
        mreq.sh = SH_16;
      end
      S_ENV_DN: begin
        mreq.a  = $signed({17'd0, tlevel}) - $signed({17'd0, env_level});
        mreq.b  = op_t'(17'h10000 - {1'b0, release_coef});
        mreq.sh = SH_16;
      end
      S_DEPTH: begin
        mreq.a  = $signed({17'd0, tdepth}) - $signed({17'd0, vib_depth});
        mreq.b  = op_t'(DEPTH_K);
        mreq.sh = SH_16;
      end
      S_SIN_T2: begin
        mreq.a  = op_t'(t);
        mreq.b  = op_t'(t);
        mreq.sh = SH_30;
      end
      S_SIN_POLY: begin
        mreq.a  = acc;
        mreq.b  = op_t'(t2);
        mreq.sh = SH_30;
      end
      S_SIN_PT: begin
        mreq.a  = acc;
        mreq.b  = op_t'(t);
        mreq.sh = SH_30;
      end
      S_OFS_A: begin
        mreq.a  = op_t'(sinv);
        mreq.b  = op_t'(vib_depth);
      end
      S_OFS_B: begin
        mreq.a  = prod1;
        mreq.b  = op_t'(glided_step);
        mreq.sh = SH_28;
      end
      S_HARM: begin
        mreq.a  = op_t'(gain);
        mreq.b  = op_t'(sinv);
      end
      S_SCALE: begin
        mreq.a  = sum;
        mreq.b  = op_t'(env_level);
        mreq.sh = SH_22;
      end
      S_OUT: begin
        mreq.a  = s;
        mreq.b  = op_t'(master_smoothed);
        mreq.sh = SH_16;
      end
      default: begin
        mreq.sh = SH_0;
      end
    endcase
  end

  assign out_r = mres;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      glide_coef      <= 16'd0;
      attack_coef     <= 16'd6554;
      release_coef    <= 16'd58982;
      percussive_mode <= 1'b0;
      master_level    <= 16'd65535;
      vibrato_step    <= 24'd0;
      harmonic_gains  <= 56'd64;
    end else if (wr_en) begin
      case (paddr[5:3])
        REG_GLIDE:   glide_coef      <= pwdata[15:0];
        REG_ATTACK:  attack_coef     <= pwdata[15:0];
        REG_RELEASE: release_coef    <= pwdata[15:0];
        REG_PERC:    percussive_mode <= pwdata[0];
        REG_MASTER:  master_level    <= pwdata[15:0];
        REG_VIBSTEP: vibrato_step    <= pwdata[23:0];
        REG_GAINS:   harmonic_gains  <= pwdata[55:0];
        default:     ;
      endcase
    end
  end

  // Sequencer, voice state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      ret             <= S_IDLE;
      out_valid       <= 1'b0;
      osc_phase       <= '0;
      vib_phase       <= '0;
      glided_step     <= '0;
      env_level       <= 16'hFFFF;
      vib_depth       <= '0;
      master_smoothed <= '0;
    end else begin
      // The final state reloads the output register itself.
      if (out_valid && !out_stall && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            tstep  <= target_step;
            tlevel <= target_level;
            tdepth <= vibrato_depth_target;
            ext    <= external_sample;
            state  <= S_MASTER;
          end
        end
        S_MASTER: begin
          master_smoothed <= master_smoothed + out_r[15:0];
          state           <= S_GLIDE;
        end
        S_GLIDE: begin
          if (percussive_mode) begin
            glided_step <= {1'b0, tstep};
          end else begin
            glided_step <= glided_step + out_r[23:0];
          end
          state <= S_ENV_UP;
        end
        S_ENV_UP: begin
          if (tlevel > env_level) begin
            env_level <= env_level + out_r[15:0];
          end
          state <= S_ENV_DN;
        end
        S_ENV_DN: begin
          if (tlevel < env_level) begin
            env_level <= env_level + out_r[15:0];
          end
          state <= S_DEPTH;
        end
        S_DEPTH: begin
          vib_depth <= vib_depth + out_r[15:0];
          osc_phase <= osc_phase + glided_step;
          vib_phase <= vib_phase + vibrato_step;
          sin_ph    <= vib_phase + vibrato_step + QUARTER_TURN;
          ret       <= S_OFS_A;
          state     <= S_SIN_LD;
        end
        S_SIN_LD: begin
          quad  <= sidx[SINE_TABLE_BITS-1 -: 2];
          t     <= 31'(frac) << (30 - QB);
          acc   <= sin_coef(3'd0);
          k     <= 3'd1;
          state <= S_SIN_T2;
        end
        S_SIN_T2: begin
          t2    <= out_r[30:0];
          state <= S_SIN_POLY;
        end
        S_SIN_POLY: begin
          acc <= sin_coef(k) + out_r[32:0];
          if (k == 3'd4) begin
            state <= S_SIN_PT;
          end else begin
            k <= k + 3'd1;
          end
        end
        S_SIN_PT: begin
          acc   <= out_r[32:0];
          state <= S_SIN_FIN;
        end
        S_SIN_FIN: begin
          sinv  <= quad[1] ? -sin_mag : sin_mag;
          state <= ret;
        end
        S_OFS_A: begin
          prod1 <= out_r[32:0];
          state <= S_OFS_B;
        end
        S_OFS_B: begin
          arg    <= osc_phase + out_r[23:0];
          sin_ph <= osc_phase + out_r[23:0];
          hidx   <= '0;
          sum    <= '0;
          ret    <= S_HARM;
          state  <= S_SIN_LD;
        end
        S_HARM: begin
          sum <= sum + out_r[32:0];
          if (int'(hidx) == HARMONIC_COUNT - 1) begin
            state <= S_SCALE;
          end else begin
            hidx   <= hidx + HW'(1);
            sin_ph <= sin_ph + arg;
            state  <= S_SIN_LD;
          end
        end
        S_SCALE: begin
          s     <= out_r[32:0] + op_t'(ext);
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            if (out_r > 66'sd32767) begin
              audio_sample <= 16'sd32767;
            end else if (out_r < -66'sd32768) begin
              audio_sample <= -16'sd32768;
            end else begin
              audio_sample <= out_r[15:0];
            end
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> sv/ahvs_mul.sv
// Shared signed multiplier with a selectable rounding right shift.
// Depends on ahvs_pkg for the request struct and the shift codes.
module ahvs_mul
  import ahvs_pkg::*;
(
  input  mul_req_t req,
  output prod_t    res
);

  prod_t       prod;
  logic        neg;
  logic [65:0] mag;
  logic [65:0] rmag;

  // Full product, then rounding on the magnitude so halves go away from zero.
  always_comb begin
    prod = req.a * req.b;
    neg  = prod[65];
    mag  = neg ? 66'(-prod) : 66'(prod);
    case (req.sh)
      SH_16:   rmag = (mag + (66'd1 << 15)) >> 16;
      SH_22:   rmag = (mag + (66'd1 << 21)) >> 22;
      SH_28:   rmag = (mag + (66'd1 << 27)) >> 28;
      SH_30:   rmag = (mag + (66'd1 << 29)) >> 30;
      default: rmag = mag;
    endcase
    res = neg ? -$signed(rmag) : $signed(rmag);
  end

endmodule

>>> test/tb_additive_harmonic_voice_synth_unit.sv
// Self-checking testbench for additive_harmonic_voice_synth_unit.
// Depends on ahvs_pkg; a built-in predictor computes every expected audio sample
// and the monitor compares each output beat against it in order.
module tb_additive_harmonic_voice_synth_unit
  import ahvs_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [22:0]        step;
    logic [15:0]        level;
    logic [15:0]        depth;
    logic signed [15:0] ext;
  } voice_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [22:0] target_step = '0;
  logic [15:0] target_level = '0;
  logic [15:0] vibrato_depth_target = '0;
  logic signed [15:0] external_sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] audio_sample;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [5:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  additive_harmonic_voice_synth_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .target_step(target_step), .target_level(target_level),
    .vibrato_depth_target(vibrato_depth_target), .external_sample(external_sample),
    .out_valid(out_valid), .out_stall(out_stall), .audio_sample(audio_sample),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor copy of the registers and voice state.
  logic [15:0] p_glide, p_attack, p_release, p_master;
  logic        p_perc;
  logic [23:0] p_vibstep;
  logic [55:0] p_gains;
  logic [23:0] s_phase, s_vphase, s_step;
  logic [15:0] s_env, s_depth, s_mgain;

  voice_beat_t beat_queue[$];
  logic signed [15:0] sample_queue[$];
  int  errors = 0;
  int  cycles = 0;
  bit  quiet = 1'b0;
  bit  stim_done = 1'b0;

  function automatic longint round_shift(longint v, int s);
    longint half;
    half = longint'(1) << (s - 1);
    if (v < 0) return -((-v + half) >>> s);
    return (v + half) >>> s;
  endfunction

  function automatic longint smooth(longint cur, longint tgt, longint k);
    return cur + round_shift((tgt - cur) * k, 16);
  endfunction

  // Quarter-folded Q15 sine from an odd degree-nine polynomial.
  function automatic longint sine15(logic [23:0] phase);
    int qb;
    longint idx, quad, qpos, frac, t, t2, acc;
    qb = SINE_TABLE_BITS_DEF - 2;
    idx = phase >> (24 - SINE_TABLE_BITS_DEF);
    quad = idx >> qb;
    qpos = idx & ((longint'(1) << qb) - 1);
    frac = quad[0] ? ((longint'(1) << qb) - qpos) : qpos;
    t = frac << (30 - qb);
    t2 = round_shift(t * t, 30);
    acc = 172273;
    acc = -5026995 + round_shift(acc * t2, 30);
    acc = 85569306 + round_shift(acc * t2, 30);
    acc = -693598668 + round_shift(acc * t2, 30);
    acc = 1686629713 + round_shift(acc * t2, 30);
    acc = round_shift(acc * t, 30);
    acc = round_shift(acc, 15);
    if (acc > 32767) acc = 32767;
    if (acc < 0) acc = 0;
    return quad[1] ? -acc : acc;
  endfunction

  // Advances the voice state by one sample and returns the output sample.
  function automatic logic signed [15:0] synth_sample(voice_beat_t b);
    longint offset, sum, s, gain;
    logic [23:0] arg, p;
    s_mgain = 16'(smooth(s_mgain, p_master, MASTER_K));
    if (p_perc) s_step = {1'b0, b.step};
    else s_step = 24'(smooth(s_step, b.step, 65536 - longint'(p_glide)));
    if (b.level > s_env) s_env = 16'(smooth(s_env, b.level, p_attack));
    if (b.level < s_env) s_env = 16'(smooth(s_env, b.level, 65536 - longint'(p_release)));
    s_phase = s_phase + s_step;
    s_vphase = s_vphase + p_vibstep;
    s_depth = 16'(smooth(s_depth, b.depth, DEPTH_K));
    offset = round_shift(sine15(s_vphase + QUARTER_TURN) * longint'(s_depth)
                         * longint'(s_step), 28);
    arg = 24'(longint'(s_phase) + offset);
    sum = 0;
    for (int h = 0; h < HARMONIC_COUNT_DEF; h++) begin
      p = 24'(longint'(arg) * (h + 1));
      gain = (h < PACKED_GAINS) ? longint'(p_gains[8*h +: 8]) : 0;
      sum += gain * sine15(p);
    end
    s = round_shift(sum * longint'(s_env), 22) + longint'(b.ext);
    s = round_shift(s * longint'(s_mgain), 16);
    if (s > 32767) s = 32767;
    if (s < -32768) s = -32768;
    return 16'(s);
  endfunction

  // Input driver: presents queued beats and predicts each accepted one.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        sample_queue.push_back(synth_sample(beat_queue.pop_front()));
      end
      // The accepted beat is already popped, so the front is the next one.
      if (!(in_valid && in_stall)) begin
        if (beat_queue.size() > 0 && (quiet || $urandom_range(99) >= 31)) begin
          in_valid <= 1'b1;
          {target_step, target_level, vibrato_depth_target, external_sample}
            <= beat_queue[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: random stall and in-order comparison.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (sample_queue.size() == 0) begin
          $display("%0t: unexpected audio_sample %0d", $time, audio_sample);
          errors <= errors + 1;
        end else if (sample_queue[0] !== audio_sample) begin
          $display("%0t: audio_sample expected %0d actual %0d", $time,
                   sample_queue[0], audio_sample);
          errors <= errors + 1;
          void'(sample_queue.pop_front());
        end else begin
          void'(sample_queue.pop_front());
        end
      end
      out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 31);
    end
  end

  // Register write over the configuration port, mirrored in the predictor.
  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 3'b000}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_GLIDE:   p_glide = val[15:0];
      REG_ATTACK:  p_attack = val[15:0];
      REG_RELEASE: p_release = val[15:0];
      REG_PERC:    p_perc = val[0];
      REG_MASTER:  p_master = val[15:0];
      REG_VIBSTEP: p_vibstep = val[23:0];
      REG_GAINS:   p_gains = val[55:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (beat_queue.size() > 0 || in_valid || sample_queue.size() > 0)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic voice_beat_t random_beat();
    voice_beat_t b;
    b.step = ($urandom_range(3) == 0) ? 23'($urandom) : 23'($urandom_range(200000));
    b.level = 16'($urandom);
    b.depth = 16'($urandom);
    b.ext = 16'($urandom);
    return b;
  endfunction

  task automatic load_config(logic [15:0] gl, logic [15:0] at, logic [15:0] rl,
                             logic pc, logic [15:0] ms, logic [23:0] vs,
                             logic [55:0] gn);
    write_reg(REG_GLIDE, 64'(gl));
    write_reg(REG_ATTACK, 64'(at));
    write_reg(REG_RELEASE, 64'(rl));
    write_reg(REG_PERC, 64'(pc));
    write_reg(REG_MASTER, 64'(ms));
    write_reg(REG_VIBSTEP, 64'(vs));
    write_reg(REG_GAINS, 64'(gn));
  endtask

  // Stimulus: reset, directed extremes, then random phases under new settings.
  initial begin
    voice_beat_t b;
    p_glide = 0; p_attack = 6554; p_release = 58982; p_perc = 0;
    p_master = 65535; p_vibstep = 0; p_gains = 56'd64;
    s_phase = 0; s_vphase = 0; s_step = 0;
    s_env = 16'hFFFF; s_depth = 0; s_mgain = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    // Directed beats under reset settings: field extremes and ramps.
    beat_queue.push_back('{23'h7FFFFF, 16'hFFFF, 16'hFFFF, 16'sh7FFF});
    beat_queue.push_back('{23'd0, 16'd0, 16'd0, -16'sh8000});
    beat_queue.push_back('{23'd0, 16'hFFFF, 16'd0, 16'sd0});
    beat_queue.push_back('{23'h400000, 16'h8000, 16'h8000, 16'sh7FFF});
    beat_queue.push_back('{23'h000001, 16'hFFFF, 16'hFFFF, -16'sh8000});
    drain();
    // Full gains, instant attack, hard saturation, percussive jumps.
    load_config(16'hFFFF, 16'hFFFF, 16'd0, 1'b1, 16'hFFFF, 24'hFFFFFF,
                56'hFFFFFFFFFFFFFF);
    for (int i = 0; i < 10; i++) begin
      b = random_beat();
      if (i < 4) b.ext = i[0] ? 16'sh7FFF : -16'sh8000;
      beat_queue.push_back(b);
    end
    drain();
    load_config(16'd0, 16'd0, 16'hFFFF, 1'b0, 16'd0, 24'd0, 56'd0);
    for (int i = 0; i < 8; i++) beat_queue.push_back(random_beat());
    drain();
    // Random phases with random settings; one phase without idling.
    for (int ph = 0; ph < 6; ph++) begin
      load_config(16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom),
                  16'($urandom), 24'($urandom), {24'($urandom), 32'($urandom)});
      quiet = (ph == 3);
      for (int i = 0; i < 72; i++) beat_queue.push_back(random_beat());
      drain();
    end
    quiet = 1'b0;
    stim_done = 1'b1;
  end

  // End of run: verdict or timeout.
  always @(posedge clk) begin
    if (stim_done) begin
      if (errors == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
    end else if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

endmodule

>>> additive_harmonic_voice_synth_unit.f
sv/ahvs_pkg.sv
sv/ahvs_mul.sv
sv/additive_harmonic_voice_synth_unit.sv
test/tb_additive_harmonic_voice_synth_unit.sv
